FILE: src/tone_queue_sequencer_macros.svh
// Assertion helpers for the tone queue sequencer.
// Both expect clk and rst_n in scope.
`ifndef TONE_QUEUE_SEQUENCER_MACROS_SVH
`define TONE_QUEUE_SEQUENCER_MACROS_SVH

// Same-cycle implication
`define TQS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tqs_pkg.sv
`timescale 1ns / 1ps
package tqs_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 32;
  localparam int QDW         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = QDW + 1;

  // Field widths
  localparam int OP_W    = 2;
  localparam int TONE_W  = 16;
  localparam int LEN_W   = 16;
  localparam int SLEN_W  = 8;
  localparam int NOTES_W = 5;

  // Period word that means silence
  localparam logic [TONE_W-1:0] SILENCE = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_SOUND = 2'd2,
    OP_STOP  = 2'd3
  } tqs_op_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TONE_W-1:0] tone;
    logic [LEN_W-1:0]  length;
  } tqs_item_t;

  typedef struct packed {
    logic               tone_on;
    logic [TONE_W-1:0]  period;
    logic               reload;
    logic               music_irq;
    logic [NOTES_W-1:0] notes_left;
    logic               refused;
  } tqs_result_t;

endpackage

FILE: src/tqs_in_if.sv
`timescale 1ns / 1ps
interface tqs_in_if
  import tqs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [TONE_W-1:0] tone;
  logic [LEN_W-1:0]  length;

  modport source (output valid, op, tone, length, input ready);
  modport sink   (input valid, op, tone, length, output ready);
endinterface

FILE: src/tqs_out_if.sv
`timescale 1ns / 1ps
interface tqs_out_if
  import tqs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               tone_on;
  logic [TONE_W-1:0]  period;
  logic               reload;
  logic               music_irq;
  logic [NOTES_W-1:0] notes_left;
  logic               refused;

  modport source (output valid, tone_on, period, reload, music_irq, notes_left, refused,
                  input ready);
  modport sink   (input valid, tone_on, period, reload, music_irq, notes_left, refused,
                  output ready);
endinterface

FILE: src/tqs_in_reg.sv
`timescale 1ns / 1ps
module tqs_in_reg
  import tqs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tqs_in_if.sink     in_bus,
  input  logic       out_free,
  output logic       step,
  output tqs_item_t  item
);

  logic      valid_r;
  tqs_item_t item_r;
  logic      accept;

  // Held item moves on whenever the result register can take it
  assign step         = valid_r && out_free;
  assign in_bus.ready = !valid_r || out_free;
  assign accept       = in_bus.valid && in_bus.ready;
  assign item         = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (step) begin
      valid_r <= 1'b0;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{op: in_bus.op, tone: in_bus.tone, length: in_bus.length};
    end
  end

endmodule

FILE: src/tqs_engine.sv
`timescale 1ns / 1ps
module tqs_engine
  import tqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  tqs_item_t   item,
  output tqs_result_t result
);

  // Note and pattern stores (contents undefined until written)
  logic [TONE_W-1:0] music_periods_r [QUEUE_DEPTH];
  logic [LEN_W-1:0]  music_lengths_r [QUEUE_DEPTH];
  logic [TONE_W-1:0] sound_periods_r [QUEUE_DEPTH];
  logic [SLEN_W-1:0] sound_lengths_r [QUEUE_DEPTH];

  // Control state
  logic [QDW-1:0]    music_head_r, music_head_nxt;
  logic [QDW-1:0]    music_tail_r, music_tail_nxt;
  logic [LEN_W-1:0]  music_wait_r, music_wait_nxt;
  logic [CNT_W-1:0]  sound_pos_r, sound_pos_nxt;
  logic [CNT_W-1:0]  sound_end_r, sound_end_nxt;
  logic [SLEN_W-1:0] sound_wait_r, sound_wait_nxt;
  logic [TONE_W-1:0] sound_repeats_r, sound_repeats_nxt;
  logic [CNT_W-1:0]  load_count_r, load_count_nxt;
  logic [TONE_W-1:0] cur_period_r, cur_period_nxt;
  logic              enabled_r, enabled_nxt;

  // Store reads and helpers
  logic [CNT_W-1:0]  snd_pos_inc;
  logic [TONE_W-1:0] snd_per;
  logic [SLEN_W-1:0] snd_len_next;
  logic [SLEN_W-1:0] snd_len_first;
  logic [QDW-1:0]    head_inc;
  logic [QDW-1:0]    tail_inc;
  logic [TONE_W-1:0] mus_per;
  logic [LEN_W-1:0]  mus_len_next;
  logic [TONE_W-1:0] tone_m1;

  logic              play_en;
  logic [TONE_W-1:0] play_per;
  logic              rl, irq, ref_flag;
  logic              music_we, sound_we;

  assign snd_pos_inc   = sound_pos_r + CNT_W'(1);
  assign snd_per       = sound_periods_r[sound_pos_r[QDW-1:0]];
  assign snd_len_next  = sound_lengths_r[snd_pos_inc[QDW-1:0]];
  assign snd_len_first = sound_lengths_r[0];
  assign head_inc      = music_head_r + QDW'(1);
  assign tail_inc      = music_tail_r + QDW'(1);
  assign mus_per       = music_periods_r[music_head_r];
  assign mus_len_next  = music_lengths_r[head_inc];
  assign tone_m1       = item.tone - TONE_W'(1);

  // Next-state logic for one item
  always_comb begin
    music_head_nxt    = music_head_r;
    music_tail_nxt    = music_tail_r;
    music_wait_nxt    = music_wait_r;
    sound_pos_nxt     = sound_pos_r;
    sound_end_nxt     = sound_end_r;
    sound_wait_nxt    = sound_wait_r;
    sound_repeats_nxt = sound_repeats_r;
    load_count_nxt    = load_count_r;
    cur_period_nxt    = cur_period_r;
    enabled_nxt       = enabled_r;
    play_en           = 1'b0;
    play_per          = snd_per;
    rl                = 1'b0;
    irq               = 1'b0;
    ref_flag          = 1'b0;
    music_we          = 1'b0;
    sound_we          = 1'b0;

    case (tqs_op_t'(item.op))
      OP_TICK: begin
        if (sound_pos_r != sound_end_r) begin
          // Sound pattern owns the output
          play_en  = 1'b1;
          play_per = snd_per;
          if (sound_wait_r <= SLEN_W'(1)) begin
            if (snd_pos_inc == sound_end_r || snd_pos_inc > CNT_W'(QUEUE_DEPTH - 1)) begin
              sound_pos_nxt = '0;
              if (sound_repeats_r > TONE_W'(1)) begin
                sound_repeats_nxt = sound_repeats_r - TONE_W'(1);
                sound_wait_nxt    = snd_len_first;
              end else begin
                sound_end_nxt     = '0;
                sound_repeats_nxt = '0;
                sound_wait_nxt    = '0;
              end
            end else begin
              sound_pos_nxt  = snd_pos_inc;
              sound_wait_nxt = snd_len_next;
            end
          end else begin
            sound_wait_nxt = sound_wait_r - SLEN_W'(1);
          end
          // Music keeps time silently
          if (music_head_r != music_tail_r) begin
            if (music_wait_r <= LEN_W'(1)) begin
              music_head_nxt = head_inc;
              music_wait_nxt = mus_len_next;
            end else begin
              music_wait_nxt = music_wait_r - LEN_W'(1);
            end
          end
        end else if (music_head_r != music_tail_r) begin
          play_en  = 1'b1;
          play_per = mus_per;
          if (music_wait_r <= LEN_W'(1)) begin
            music_head_nxt = head_inc;
            music_wait_nxt = mus_len_next;
            irq            = (head_inc + QDW'(1)) == music_tail_r;
          end else begin
            music_wait_nxt = music_wait_r - LEN_W'(1);
          end
        end else begin
          enabled_nxt = 1'b0;
        end
      end

      OP_PUSH: begin
        if (tail_inc == music_head_r) begin
          ref_flag = 1'b1;
        end else begin
          if (music_head_r == music_tail_r) begin
            music_wait_nxt = item.length;
          end
          music_we       = 1'b1;
          music_tail_nxt = tail_inc;
        end
      end

      OP_SOUND: begin
        // First entry of a new load drops the old pattern
        if (load_count_r == '0) begin
          sound_pos_nxt     = '0;
          sound_end_nxt     = '0;
          sound_repeats_nxt = '0;
        end
        if (item.length != '0) begin
          if (load_count_r >= CNT_W'(QUEUE_DEPTH)) begin
            ref_flag = 1'b1;
          end else begin
            sound_we       = 1'b1;
            load_count_nxt = load_count_r + CNT_W'(1);
          end
        end else begin
          // Terminator: arm the pattern
          sound_repeats_nxt = item.tone;
          sound_pos_nxt     = '0;
          sound_end_nxt     = load_count_r;
          sound_wait_nxt    = snd_len_first;
          load_count_nxt    = '0;
        end
      end

      default: begin
        // Stop and clear
        music_head_nxt    = '0;
        music_tail_nxt    = '0;
        music_wait_nxt    = '0;
        sound_pos_nxt     = '0;
        sound_end_nxt     = '0;
        sound_wait_nxt    = '0;
        sound_repeats_nxt = '0;
        load_count_nxt    = '0;
        cur_period_nxt    = '0;
        enabled_nxt       = 1'b0;
        rl                = 1'b1;
      end
    endcase

    // Tone drive: silence word mutes, a new period reloads the PWM
    if (play_en) begin
      if (play_per != SILENCE) begin
        enabled_nxt = 1'b1;
        if (play_per != cur_period_r) begin
          cur_period_nxt = play_per;
          rl             = 1'b1;
        end
      end else begin
        enabled_nxt = 1'b0;
      end
    end
  end

  assign result = '{
    tone_on:    enabled_nxt,
    period:     cur_period_nxt,
    reload:     rl,
    music_irq:  irq,
    notes_left: NOTES_W'(music_tail_nxt - music_head_nxt),
    refused:    ref_flag
  };

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      music_head_r    <= '0;
      music_tail_r    <= '0;
      music_wait_r    <= '0;
      sound_pos_r     <= '0;
      sound_end_r     <= '0;
      sound_wait_r    <= '0;
      sound_repeats_r <= '0;
      load_count_r    <= '0;
      cur_period_r    <= '0;
      enabled_r       <= 1'b0;
    end else if (step) begin
      music_head_r    <= music_head_nxt;
      music_tail_r    <= music_tail_nxt;
      music_wait_r    <= music_wait_nxt;
      sound_pos_r     <= sound_pos_nxt;
      sound_end_r     <= sound_end_nxt;
      sound_wait_r    <= sound_wait_nxt;
      sound_repeats_r <= sound_repeats_nxt;
      load_count_r    <= load_count_nxt;
      cur_period_r    <= cur_period_nxt;
      enabled_r       <= enabled_nxt;
    end
  end

  // Store writes
  always_ff @(posedge clk) begin
    if (step && music_we) begin
      music_periods_r[music_tail_r] <= tone_m1;
      music_lengths_r[music_tail_r] <= item.length;
    end
    if (step && sound_we) begin
      sound_periods_r[load_count_r[QDW-1:0]] <= tone_m1;
      sound_lengths_r[load_count_r[QDW-1:0]] <= item.length[SLEN_W-1:0];
    end
  end

endmodule

FILE: src/tqs_out_reg.sv
`timescale 1ns / 1ps
module tqs_out_reg
  import tqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  tqs_result_t result,
  tqs_out_if.source   out_bus,
  output logic        out_free
);

  logic        valid_r;
  tqs_result_t result_r;

  assign out_free = !valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step) begin
      valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result;
    end
  end

  assign out_bus.valid      = valid_r;
  assign out_bus.tone_on    = result_r.tone_on;
  assign out_bus.period     = result_r.period;
  assign out_bus.reload     = result_r.reload;
  assign out_bus.music_irq  = result_r.music_irq;
  assign out_bus.notes_left = result_r.notes_left;
  assign out_bus.refused    = result_r.refused;

endmodule

FILE: src/tone_queue_sequencer.sv
`timescale 1ns / 1ps
`include "tone_queue_sequencer_macros.svh"
// Square-wave tone sequencer with a music note ring and a looping sound pattern.
// in_bus  : valid/ready transactions of {op, tone, length}. op selects tick,
//           push music note, load sound entry, or stop and clear.
// out_bus : valid/ready transactions, one per input transaction, in order:
//           tone_on, period word, reload strobe, music_irq, notes_left, refused.
// Throughput: one transaction per cycle while the receiver takes results.
// Each item is captured in an input register, processed in one pass of the
// update logic (state, pointers and the 32-entry register stores) and lands
// in the result register.
// Reset (synchronous, active low) clears pointers, waits, counts, the period
// and the tone enable; store contents stay undefined until written.
// When the receiver stalls, the result register holds its transaction and the
// input register takes one more item, after which in_bus.ready drops until the
// result is taken.
module tone_queue_sequencer
  import tqs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tqs_in_if.sink    in_bus,
  tqs_out_if.source out_bus
);

  logic        step;
  logic        out_free;
  tqs_item_t   item;
  tqs_result_t result;

  tqs_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_free (out_free),
    .step     (step),
    .item     (item)
  );

  tqs_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .result (result)
  );

  tqs_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .result   (result),
    .out_bus  (out_bus),
    .out_free (out_free)
  );

  // Interrupt only fires with a single note left
  `TQS_ASSERT_IMPL(a_irq_one_left, out_bus.valid && out_bus.music_irq, out_bus.notes_left == NOTES_W'(1), "music_irq without exactly one note left")
  // A reload with the tone off can only come from stop and clear
  `TQS_ASSERT_IMPL(a_stop_reload, out_bus.valid && out_bus.reload && !out_bus.tone_on, out_bus.period == '0, "reload with tone off but nonzero period")
  // A refused push or sound load changes nothing on the tone side
  `TQS_ASSERT_IMPL(a_refused_quiet, out_bus.valid && out_bus.refused, !out_bus.reload && !out_bus.music_irq, "refused transaction carries reload or irq")
  // Every processed item shows up on the output next cycle
  `TQS_ASSERT_NEXT(a_step_to_out, step, out_bus.valid, "processed item did not reach the output")

endmodule
